@@ design/utf8_stream_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared property forms for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utf8 decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utf8 decoder check failed");

`endif

@@ design/utf8sd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Constants and types shared by the decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

	localparam int ScalarW = 21;
	localparam int QDepth  = 4;
	localparam int QPtrW   = $clog2(QDepth);
	localparam int QCntW   = $clog2(QDepth + 1);

	localparam logic [ScalarW-1:0] ReplChar  = 21'h00FFFD;
	localparam logic [ScalarW-1:0] MaxScalar = 21'h10FFFF;
	localparam logic [ScalarW-1:0] SurrLow   = 21'h00D800;
	localparam logic [ScalarW-1:0] SurrHigh  = 21'h00DFFF;
	localparam logic [ScalarW-1:0] Min2Byte  = 21'h000080;
	localparam logic [ScalarW-1:0] Min3Byte  = 21'h000800;
	localparam logic [ScalarW-1:0] Min4Byte  = 21'h010000;

	localparam logic [7:0] Lead2Lo = 8'hC2;
	localparam logic [7:0] Lead3Lo = 8'hE0;
	localparam logic [7:0] Lead4Lo = 8'hF0;
	localparam logic [7:0] Lead4Hi = 8'hF5;
	localparam logic [7:0] ContMask = 8'hC0;
	localparam logic [7:0] ContTag  = 8'h80;

	// continuation counts of an open sequence
	localparam logic [1:0] LenNone = 2'd0;
	localparam logic [1:0] Len2    = 2'd1;
	localparam logic [1:0] Len3    = 2'd2;
	localparam logic [1:0] Len4    = 2'd3;

	typedef struct packed {
		logic [ScalarW-1:0] value;
		logic               repl;
	} res_t;

	// all results caused by one byte
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ design/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Turns a byte stream of UTF-8 text into Unicode scalar values.
// ----------------------------------------------------------------------------
// Input stream s_*: one byte per request in s_tdata, s_tlast marks the last
// byte of the text. Output stream m_*: one scalar per request in
// m_tdata[20:0], m_tuser set when the value is a U+FFFD substitution, and
// m_tlast set on the final result caused by an input byte.
// A byte yields zero, one or two results; a lead byte opening a sequence
// yields none until the sequence completes.
// A result is written into the result queue and then loaded into the output
// register before it shows on m_tvalid.
// Throughput: one byte per cycle while the result queue is not full and each
// byte yields at most one result; a byte that yields two results sends them
// back to back, and the four-entry result queue absorbs the difference.
// s_tready drops only when the result queue is full, so a stalled receiver
// fills the queue and then stops the sender; nothing is lost.
// Reset clears the open sequence, the queue and the output register.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] scalar_value, [23:21] zero
	output logic        m_tuser,   // [0] replaced
	output logic        m_tlast    // last_of_run
);

	logic                accept;
	logic                push;
	logic                pop;
	utf8sd_pkg::entry_t  push_data;
	utf8sd_pkg::entry_t  pop_data;
	utf8sd_pkg::q_stat_t stat;
	utf8sd_pkg::res_t    out_res;
	logic                value_is_repl;
	logic                value_legal;
	logic                pair_open;

	assign s_tready = !stat.full;
	assign accept   = s_tvalid && s_tready;

	utf8sd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (s_tdata),
		.end_of_text (s_tlast),
		.push        (push),
		.entry       (push_data)
	);

	utf8sd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	utf8sd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, out_res.value};
	assign m_tuser = out_res.repl;

	assign value_is_repl = out_res.value == utf8sd_pkg::ReplChar;
	assign value_legal   = (out_res.value <= utf8sd_pkg::MaxScalar) &&
		((out_res.value < utf8sd_pkg::SurrLow) || (out_res.value > utf8sd_pkg::SurrHigh));
	assign pair_open     = m_tvalid && m_tready && !m_tlast;

	// substitutions always carry U+FFFD
	`U8SD_ASSERT_NOW(a_repl_value, clk, arst_n, m_tvalid && m_tuser, value_is_repl)
	// no surrogate or out-of-range value ever leaves as a decoded scalar
	`U8SD_ASSERT_NOW(a_scalar_range, clk, arst_n, m_tvalid && !m_tuser, value_legal)
	// second result of a byte follows the first without a gap
	`U8SD_ASSERT_NEXT(a_pair_back_to_back, clk, arst_n, pair_open, m_tvalid && m_tlast)
	// the queue never takes an entry while full
	`U8SD_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !stat.full)

endmodule

@@ design/utf8sd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Classifies each accepted byte, tracks the open sequence and builds the
// results that the byte causes as one queue entry.
// ----------------------------------------------------------------------------
module utf8sd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                end_of_text,
	output logic                push,
	output utf8sd_pkg::entry_t  entry
);

	logic [utf8sd_pkg::ScalarW-1:0] acc_q;
	logic [1:0]                     rem_q;
	logic [1:0]                     len_q;

	logic                           is_cont;
	logic                           is_ascii;
	logic                           is_l2;
	logic                           is_l3;
	logic                           is_l4;
	logic                           lead_open;
	logic [utf8sd_pkg::ScalarW-1:0] lead_acc;
	logic [1:0]                     lead_len;
	logic                           lead_has;
	utf8sd_pkg::res_t               lead_res;
	utf8sd_pkg::res_t               repl_res;

	logic [utf8sd_pkg::ScalarW-1:0] acc_shift;
	logic [1:0]                     rem_dec;
	logic                           code_ok;

	logic                           has0;
	logic [utf8sd_pkg::ScalarW-1:0] acc_d;
	logic [1:0]                     rem_d;
	logic [1:0]                     len_d;

	assign is_cont  = (data_byte & utf8sd_pkg::ContMask) == utf8sd_pkg::ContTag;
	assign is_ascii = ~data_byte[7];
	assign is_l4    = (data_byte >= utf8sd_pkg::Lead4Lo) && (data_byte < utf8sd_pkg::Lead4Hi);
	assign is_l3    = (data_byte >= utf8sd_pkg::Lead3Lo) && (data_byte < utf8sd_pkg::Lead4Lo);
	assign is_l2    = (data_byte >= utf8sd_pkg::Lead2Lo) && (data_byte < utf8sd_pkg::Lead3Lo);

	assign repl_res.value = utf8sd_pkg::ReplChar;
	assign repl_res.repl  = 1'b1;

	// byte taken as a new lead
	always_comb begin
		lead_open = 1'b0;
		lead_acc  = '0;
		lead_len  = utf8sd_pkg::LenNone;
		lead_has  = 1'b1;
		lead_res  = repl_res;
		if (is_ascii) begin
			lead_res.value = utf8sd_pkg::ScalarW'(data_byte);
			lead_res.repl  = 1'b0;
		end else if (is_l2 || is_l3 || is_l4) begin
			if (is_l4) begin
				lead_acc = utf8sd_pkg::ScalarW'(data_byte[2:0]);
				lead_len = utf8sd_pkg::Len4;
			end else if (is_l3) begin
				lead_acc = utf8sd_pkg::ScalarW'(data_byte[3:0]);
				lead_len = utf8sd_pkg::Len3;
			end else begin
				lead_acc = utf8sd_pkg::ScalarW'(data_byte[4:0]);
				lead_len = utf8sd_pkg::Len2;
			end
			// a lead on the final byte closes at once with a replacement
			lead_open = ~end_of_text;
			lead_has  = end_of_text;
		end
	end

	assign acc_shift = {acc_q[utf8sd_pkg::ScalarW-7:0], data_byte[5:0]};
	assign rem_dec   = rem_q - 2'd1;

	always_comb begin
		code_ok = (acc_shift <= utf8sd_pkg::MaxScalar) &&
			!((acc_shift >= utf8sd_pkg::SurrLow) && (acc_shift <= utf8sd_pkg::SurrHigh));
		case (len_q)
			utf8sd_pkg::Len2: if (acc_shift < utf8sd_pkg::Min2Byte) code_ok = 1'b0;
			utf8sd_pkg::Len3: if (acc_shift < utf8sd_pkg::Min3Byte) code_ok = 1'b0;
			utf8sd_pkg::Len4: if (acc_shift < utf8sd_pkg::Min4Byte) code_ok = 1'b0;
			default: ;
		endcase
	end

	always_comb begin
		has0      = 1'b0;
		entry.two = 1'b0;
		entry.r0  = repl_res;
		entry.r1  = lead_res;
		acc_d     = '0;
		rem_d     = '0;
		len_d     = utf8sd_pkg::LenNone;
		if (rem_q != 2'd0 && is_cont) begin
			if (rem_dec == 2'd0) begin
				has0 = 1'b1;
				if (code_ok) begin
					entry.r0.value = acc_shift;
					entry.r0.repl  = 1'b0;
				end
			end else if (end_of_text) begin
				has0 = 1'b1;
			end else begin
				acc_d = acc_shift;
				rem_d = rem_dec;
				len_d = len_q;
			end
		end else begin
			if (rem_q != 2'd0) begin
				// broken sequence: replace, then reprocess the byte as a lead
				has0      = 1'b1;
				entry.two = lead_has;
			end else begin
				has0     = lead_has;
				entry.r0 = lead_res;
			end
			if (lead_open) begin
				acc_d = lead_acc;
				rem_d = lead_len;
				len_d = lead_len;
			end
		end
	end

	assign push = accept && has0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
			len_q <= utf8sd_pkg::LenNone;
		end else if (accept) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
			len_q <= len_d;
		end
	end

endmodule

@@ design/utf8sd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Short FIFO of per-byte result entries between the front and back ends.
// ----------------------------------------------------------------------------
module utf8sd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utf8sd_pkg::entry_t  push_data,
	input  logic                pop,
	output utf8sd_pkg::entry_t  pop_data,
	output utf8sd_pkg::q_stat_t stat
);

	utf8sd_pkg::entry_t              mem_q [utf8sd_pkg::QDepth];
	logic [utf8sd_pkg::QPtrW-1:0]    wr_ptr_q;
	logic [utf8sd_pkg::QPtrW-1:0]    rd_ptr_q;
	logic [utf8sd_pkg::QCntW-1:0]    cnt_q;

	assign stat.full  = cnt_q == utf8sd_pkg::QCntW'(utf8sd_pkg::QDepth);
	assign stat.empty = cnt_q == '0;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/utf8sd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Drains queue entries and sends their results one per request through an
// output register.
// ----------------------------------------------------------------------------
module utf8sd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  utf8sd_pkg::q_stat_t stat,
	input  utf8sd_pkg::entry_t  pop_data,
	output logic                pop,
	input  logic                out_ready,
	output logic                out_valid,
	output utf8sd_pkg::res_t    out_res,
	output logic                out_last
);

	logic             out_valid_q;
	logic             pend_q;
	utf8sd_pkg::res_t out_res_q;
	logic             out_last_q;
	utf8sd_pkg::res_t hold_q;
	logic             load;

	assign load = !out_valid_q || out_ready;
	assign pop  = load && !pend_q && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= !stat.empty;
				pend_q      <= !stat.empty && pop_data.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_res_q  <= hold_q;
				out_last_q <= 1'b1;
			end else begin
				out_res_q  <= pop_data.r0;
				out_last_q <= !pop_data.two;
				hold_q     <= pop_data.r1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_last  = out_last_q;

endmodule

@@ sim/utf8_stream_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds byte streams to the decoder and checks every scalar it returns. A
// short table of hand-picked bytes comes first. It is followed by random
// text: mostly well-formed characters with random content, mixed with
// overlong forms, surrogates, truncated sequences and stray bytes. A model
// of the decoder running alongside predicts the scalars. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------

module utf8_stream_decoder_test;

	// one decoded scalar as the block should return it
	typedef struct packed {
		logic [utf8sd_pkg::ScalarW-1:0] scalar;
		logic                           repl;
		logic                           last_of_run;
	} decoded_t;

	// one row of hand-picked text; typed rows carry their single result
	typedef struct packed {
		logic [7:0]                     data_byte;
		logic                           eot;
		logic                           typed;
		logic [utf8sd_pkg::ScalarW-1:0] scalar;
		logic                           repl;
	} text_row_t;

	localparam int RowCount = 23;

	localparam text_row_t DirectedText [RowCount] = '{
		'{8'h00, 1'b0, 1'b1, 21'h000000,            1'b0},
		'{8'h7F, 1'b1, 1'b1, 21'h00007F,            1'b0},
		'{8'h80, 1'b0, 1'b1, utf8sd_pkg::ReplChar,  1'b1},   // stray continuation
		'{8'hC0, 1'b0, 1'b1, utf8sd_pkg::ReplChar,  1'b1},   // never a lead
		'{8'hFF, 1'b0, 1'b1, utf8sd_pkg::ReplChar,  1'b1},
		'{8'hF4, 1'b0, 1'b0, 21'h0,                 1'b0},   // U+10FFFF
		'{8'h8F, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'hBF, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'hBF, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'hEF, 1'b0, 1'b0, 21'h0,                 1'b0},   // encoded U+FFFD, not replaced
		'{8'hBF, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'hBD, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'hE0, 1'b0, 1'b0, 21'h0,                 1'b0},   // overlong
		'{8'h80, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'h80, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'hED, 1'b0, 1'b0, 21'h0,                 1'b0},   // surrogate
		'{8'hA0, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'h80, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'hE2, 1'b0, 1'b0, 21'h0,                 1'b0},   // broken by an ASCII byte
		'{8'h41, 1'b0, 1'b0, 21'h0,                 1'b0},
		'{8'hC2, 1'b1, 1'b1, utf8sd_pkg::ReplChar,  1'b1},   // lead as the final byte
		'{8'hF0, 1'b0, 1'b0, 21'h0,                 1'b0},   // open at end of text
		'{8'h90, 1'b1, 1'b0, 21'h0,                 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;    // [7:0] data_byte
	logic        s_tlast = 1'b0;     // end_of_text
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;            // [20:0] scalar_value, [23:21] zero
	logic        m_tuser;            // [0] replaced
	logic        m_tlast;            // last_of_run

	decoded_t pending_scalars[$];
	int fail_count = 0;
	int send_gap_max = 10;
	int recv_gap_max = 10;

	// decoder model state
	logic [utf8sd_pkg::ScalarW-1:0] open_code;
	logic [1:0]                     conts_left;
	logic [1:0]                     conts_total;

	utf8_stream_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic int pick_idle_limit();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 10;
		endcase
	endfunction

	function automatic void push_scalar(input logic [utf8sd_pkg::ScalarW-1:0] v,
			input logic r);
		decoded_t d;
		d.scalar = v;
		d.repl = r;
		d.last_of_run = 1'b0;
		pending_scalars = {pending_scalars, d};
	endfunction

	function automatic void close_open_code();
		open_code = '0;
		conts_left = utf8sd_pkg::LenNone;
		conts_total = utf8sd_pkg::LenNone;
	endfunction

	function automatic logic completed_scalar_ok(input logic [utf8sd_pkg::ScalarW-1:0] v,
			input logic [1:0] n);
		if (v > utf8sd_pkg::MaxScalar)
			return 1'b0;
		if (v >= utf8sd_pkg::SurrLow && v <= utf8sd_pkg::SurrHigh)
			return 1'b0;
		case (n)
			utf8sd_pkg::Len2: return v >= utf8sd_pkg::Min2Byte;
			utf8sd_pkg::Len3: return v >= utf8sd_pkg::Min3Byte;
			default: return v >= utf8sd_pkg::Min4Byte;
		endcase
	endfunction

	// byte seen with no sequence open
	function automatic void take_lead_byte(input logic [7:0] b, input logic eot);
		if (b < utf8sd_pkg::ContTag) begin
			push_scalar(utf8sd_pkg::ScalarW'(b), 1'b0);
			return;
		end
		if (b >= utf8sd_pkg::Lead4Lo && b < utf8sd_pkg::Lead4Hi) begin
			open_code = utf8sd_pkg::ScalarW'(b[2:0]);
			conts_total = utf8sd_pkg::Len4;
		end else if (b >= utf8sd_pkg::Lead3Lo && b < utf8sd_pkg::Lead4Lo) begin
			open_code = utf8sd_pkg::ScalarW'(b[3:0]);
			conts_total = utf8sd_pkg::Len3;
		end else if (b >= utf8sd_pkg::Lead2Lo && b < utf8sd_pkg::Lead3Lo) begin
			open_code = utf8sd_pkg::ScalarW'(b[4:0]);
			conts_total = utf8sd_pkg::Len2;
		end else begin
			push_scalar(utf8sd_pkg::ReplChar, 1'b1);
			return;
		end
		conts_left = conts_total;
		if (eot) begin
			close_open_code();
			push_scalar(utf8sd_pkg::ReplChar, 1'b1);
		end
	endfunction

	// advance the model by one byte; returns how many scalars it adds
	function automatic int decode_utf8_byte(input logic [7:0] b, input logic eot);
		int n0;
		decoded_t tail;
		n0 = pending_scalars.size();
		if (conts_left != utf8sd_pkg::LenNone &&
				(b & utf8sd_pkg::ContMask) == utf8sd_pkg::ContTag) begin
			open_code = {open_code[utf8sd_pkg::ScalarW-7:0], b[5:0]};
			conts_left = conts_left - 2'd1;
			if (conts_left == utf8sd_pkg::LenNone) begin
				if (completed_scalar_ok(open_code, conts_total))
					push_scalar(open_code, 1'b0);
				else
					push_scalar(utf8sd_pkg::ReplChar, 1'b1);
				close_open_code();
			end else if (eot) begin
				close_open_code();
				push_scalar(utf8sd_pkg::ReplChar, 1'b1);
			end
		end else begin
			// a broken sequence is flushed, then the byte starts over as a lead
			if (conts_left != utf8sd_pkg::LenNone) begin
				close_open_code();
				push_scalar(utf8sd_pkg::ReplChar, 1'b1);
			end
			take_lead_byte(b, eot);
		end
		if (pending_scalars.size() > n0) begin
			tail = pending_scalars.pop_back();
			tail.last_of_run = 1'b1;
			pending_scalars = {pending_scalars, tail};
		end
		return pending_scalars.size() - n0;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
			input logic [utf8sd_pkg::ScalarW-1:0] t_scalar, input logic t_repl);
		int gap;
		int n;
		decoded_t d;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eot;
		do @(posedge clk); while (!s_tready);
		n = decode_utf8_byte(b, eot);
		if (typed) begin
			// replace the model's result with the one written in the row
			repeat (n) d = pending_scalars.pop_back();
			d.scalar = t_scalar;
			d.repl = t_repl;
			d.last_of_run = 1'b1;
			pending_scalars = {pending_scalars, d};
		end
	endtask

	// drop valid and wait for every outstanding scalar
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_scalars.size() != 0);
	endtask

	// one random character, well-formed or not, with end of text now and then
	task automatic send_random_text(output int count);
		logic [7:0] seq[$];
		logic [20:0] v;
		int kind;
		int n;
		int eot_pos;
		kind = $urandom_range(0, 12);
		case (kind)
			0, 1: seq = {seq, 8'($urandom_range(0, 127))};
			2: begin
				v = 21'($urandom_range(21'h80, 21'h7FF));
				seq = {seq, {3'b110, v[10:6]}};
				seq = {seq, {2'b10, v[5:0]}};
			end
			3, 4: begin
				v = 21'($urandom_range(21'h800, 21'hFFFF));
				seq = {seq, {4'b1110, v[15:12]}};
				seq = {seq, {2'b10, v[11:6]}};
				seq = {seq, {2'b10, v[5:0]}};
			end
			5, 6, 11: begin
				v = 21'($urandom_range(21'h10000, 21'h10FFFF));
				seq = {seq, {5'b11110, v[20:18]}};
				seq = {seq, {2'b10, v[17:12]}};
				seq = {seq, {2'b10, v[11:6]}};
				seq = {seq, {2'b10, v[5:0]}};
				// truncate the sequence
				if (kind == 11)
					repeat ($urandom_range(1, 3)) void'(seq.pop_back());
			end
			7: begin
				seq = {seq, 8'($urandom_range(8'hC2, 8'hF4))};
				n = $urandom_range(1, 3);
				repeat (n) seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
			end
			8: begin
				seq = {seq, 8'($urandom_range(8'hC0, 8'hFF))};
				n = $urandom_range(0, 3);
				repeat (n) seq = {seq, 8'($urandom_range(0, 255))};
			end
			9, 10: seq = {seq, 8'($urandom_range(0, 255))};
			default: begin
				// overlong, surrogate, above the last scalar
				case ($urandom_range(0, 3))
					0: begin
						seq = {seq, 8'hE0};
						seq = {seq, 8'($urandom_range(8'h80, 8'h9F))};
					end
					1: begin
						seq = {seq, 8'hED};
						seq = {seq, 8'($urandom_range(8'hA0, 8'hBF))};
					end
					2: begin
						seq = {seq, 8'hF4};
						seq = {seq, 8'($urandom_range(8'h90, 8'hBF))};
						seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
					end
					default: begin
						seq = {seq, 8'hF0};
						seq = {seq, 8'($urandom_range(8'h80, 8'h8F))};
						seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
					end
				endcase
				seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
			end
		endcase
		eot_pos = -1;
		if ($urandom_range(0, 15) == 0)
			eot_pos = seq.size() - 1;
		else if ($urandom_range(0, 39) == 0)
			eot_pos = $urandom_range(0, seq.size() - 1);
		foreach (seq[i])
			send_byte(seq[i], i == eot_pos, 1'b0, '0, 1'b0);
		count = seq.size();
	endtask

	// receive side: random stalls, compare each scalar with the oldest prediction
	initial begin
		decoded_t want;
		int gap;
		while (!arst_n) @(posedge clk);
		forever begin
			gap = $urandom_range(0, recv_gap_max);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_scalars.size() == 0) begin
				$error("unexpected result: scalar_value %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_scalars.pop_front();
				if (m_tdata !== {3'b000, want.scalar}) begin
					$error("scalar_value: expected %h, got %h", want.scalar, m_tdata);
					fail_count++;
				end
				if (m_tuser !== want.repl) begin
					$error("replaced: expected %b, got %b", want.repl, m_tuser);
					fail_count++;
				end
				if (m_tlast !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b", want.last_of_run, m_tlast);
					fail_count++;
				end
			end
			if ($urandom_range(0, 39) == 0)
				recv_gap_max = pick_idle_limit();
		end
	end

	initial begin
		int sent;
		int n;
		logic drained_midway;
		close_open_code();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DirectedText[i])
			send_byte(DirectedText[i].data_byte, DirectedText[i].eot, DirectedText[i].typed,
				DirectedText[i].scalar, DirectedText[i].repl);
		hold_until_drained();
		sent = 0;
		drained_midway = 1'b0;
		while (sent < 1300) begin
			if ($urandom_range(0, 29) == 0)
				send_gap_max = pick_idle_limit();
			send_random_text(n);
			sent += n;
			if (!drained_midway && sent >= 650) begin
				drained_midway = 1'b1;
				hold_until_drained();
			end
		end
		hold_until_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("utf8_stream_decoder: match");
		else
			$display("utf8_stream_decoder: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("utf8_stream_decoder: mismatch");
		$finish;
	end

endmodule
